// ===== rtl/core/hsv_color_wheel_pixel_assert.svh =====
// assertion macros for the color wheel pixel generator
`ifndef HSV_COLOR_WHEEL_PIXEL_ASSERT_SVH
`define HSV_COLOR_WHEEL_PIXEL_ASSERT_SVH
`ifndef ASSERT_OFF
`define HCW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define HCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HCW_ASSERT(lbl, cond, msg)
`define HCW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/hcw_pkg.sv =====
`default_nettype none
package hcw_pkg;

  // algorithm settings
  localparam int CORDIC_STEPS    = 16;
  localparam int FRAC_BITS       = 16;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int VEC_SHIFT       = 20;
  localparam int DIST_FRAC       = 20;

  // field widths
  localparam int COORD_W = 11;
  localparam int RAD_W   = 10;
  localparam int BYTE_W  = 8;
  localparam int DELTA_W = COORD_W + 1;
  localparam int D2_W    = 2 * DELTA_W - 2;
  localparam int SQ_W    = 2 * RAD_W;

  // cordic datapath
  localparam int ANG_W    = 32;
  localparam int CORDIC_W = DELTA_W + VEC_SHIFT + 2;
  localparam logic [ANG_W-1:0] ANG_HALF = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic [ANG_W:0]   HUE_RND  = (ANG_W+1)'(64'd1 << (ANG_W - 1 - FRAC_BITS));

  // square root and divider
  localparam int SQRT_BITS = (SQ_W + 2 * DIST_FRAC) / 2;
  localparam int REM_W     = SQRT_BITS + 3;
  localparam int NUM_SHIFT = (FRAC_BITS > DIST_FRAC) ? FRAC_BITS - DIST_FRAC : 0;
  localparam int DEN_SHIFT = (DIST_FRAC > FRAC_BITS) ? DIST_FRAC - FRAC_BITS : 0;
  localparam int NUM_W     = SQRT_BITS + NUM_SHIFT;
  localparam int DIV_W     = NUM_W + 1;
  localparam int DIV_BITS  = FRAC_BITS + 1;

  // stage counts of the two parallel units
  localparam int LAT_CORDIC = CORDIC_STEPS + 1;
  localparam int LAT_SAT    = SQRT_BITS + DIV_BITS;
  localparam int HUE_DLY    = LAT_SAT - LAT_CORDIC;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // atan(2^-i) in binary turns
  localparam logic [ANG_W-1:0] ATAN_TURNS [ANGLE_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } hcw_in_t;

  typedef struct packed {
    logic              inside_res;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } hcw_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/hcw_cordic.sv =====
`default_nettype none
module hcw_cordic (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [hcw_pkg::DELTA_W-1:0]   vec_x,
  input  logic signed [hcw_pkg::DELTA_W-1:0]   vec_y,
  output logic        [hcw_pkg::ANG_W-1:0]     angle
);
  import hcw_pkg::*;

  logic signed [CORDIC_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_r [CORDIC_STEPS+1];
  logic        [ANG_W-1:0]    z_r [CORDIC_STEPS+1];

  logic signed [CORDIC_W-1:0] sx, sy, x0_nxt, y0_nxt;
  logic        [ANG_W-1:0]    z0_nxt;

  // scale up and fold the left half plane onto the right one
  always_comb begin
    sx = CORDIC_W'(vec_x) <<< VEC_SHIFT;
    sy = CORDIC_W'(vec_y) <<< VEC_SHIFT;
    if (vec_x < 0) begin
      x0_nxt = -sx;
      y0_nxt = -sy;
      z0_nxt = ANG_HALF;
    end else begin
      x0_nxt = sx;
      y0_nxt = sy;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0_nxt;
      y_r[0] <= y0_nxt;
      z_r[0] <= z0_nxt;
    end
  end

  // one vectoring step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CORDIC_W-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ATAN_TURNS[i];
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ATAN_TURNS[i];
        end
      end
    end
  end

  assign angle = z_r[CORDIC_STEPS];

endmodule
`default_nettype wire

// ===== rtl/core/hcw_satdiv.sv =====
`default_nettype none
module hcw_satdiv (
  input  logic                             clk,
  input  logic                             en,
  input  logic [hcw_pkg::SQ_W-1:0]         d2,
  input  logic [hcw_pkg::RAD_W-1:0]        rad,
  output logic [hcw_pkg::DIV_BITS-1:0]     sat
);
  import hcw_pkg::*;

  logic [REM_W-1:0]     rem_r  [SQRT_BITS];
  logic [SQRT_BITS-1:0] root_r [SQRT_BITS];
  logic [SQ_W-1:0]      bits_r [SQRT_BITS];
  logic [RAD_W-1:0]     srad_r [SQRT_BITS];

  // restoring square root of d2 scaled by 2^(2*DIST_FRAC), one root bit per stage
  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_sqrt
    logic [REM_W-1:0]     rem_in, rem_sh, trial;
    logic [SQRT_BITS-1:0] root_in;
    logic [SQ_W-1:0]      bits_in;
    logic [RAD_W-1:0]     rad_in;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign bits_in = d2;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign bits_in = bits_r[i-1];
      assign rad_in  = srad_r[i-1];
    end
    assign rem_sh = {rem_in[REM_W-3:0], bits_in[SQ_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        bits_r[i] <= {bits_in[SQ_W-3:0], 2'b00};
        srad_r[i] <= rad_in;
        if (rem_sh >= trial) begin
          rem_r[i]  <= rem_sh - trial;
          root_r[i] <= {root_in[SQRT_BITS-2:0], 1'b1};
        end else begin
          rem_r[i]  <= rem_sh;
          root_r[i] <= {root_in[SQRT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  logic [DIV_W-1:0]    drem_r [DIV_BITS];
  logic [DIV_BITS-1:0] quo_r  [DIV_BITS];
  logic [RAD_W-1:0]    drad_r [DIV_BITS];

  // restoring divide of the distance by the radius, quotient msb first
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [DIV_W-1:0]    drem_in, dsh;
    logic [DIV_BITS-1:0] quo_in;
    logic [RAD_W-1:0]    rad_in;
    if (j == 0) begin : g_first
      assign drem_in = DIV_W'(root_r[SQRT_BITS-1]) << NUM_SHIFT;
      assign quo_in  = '0;
      assign rad_in  = srad_r[SQRT_BITS-1];
    end else begin : g_next
      assign drem_in = drem_r[j-1];
      assign quo_in  = quo_r[j-1];
      assign rad_in  = drad_r[j-1];
    end
    assign dsh = DIV_W'(rad_in) << (DEN_SHIFT + DIV_BITS - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        drad_r[j] <= rad_in;
        if (drem_in >= dsh) begin
          drem_r[j] <= drem_in - dsh;
          quo_r[j]  <= {quo_in[DIV_BITS-2:0], 1'b1};
        end else begin
          drem_r[j] <= drem_in;
          quo_r[j]  <= {quo_in[DIV_BITS-2:0], 1'b0};
        end
      end
    end
  end

  assign sat = quo_r[DIV_BITS-1];

endmodule
`default_nettype wire

// ===== rtl/core/hsv_color_wheel_pixel.sv =====
// pipeline from an accepted input word to out_valid: three setup stages,
//   SQRT_BITS + FRAC_BITS + 1 stages of square root and divider, four color stages, output
// throughput: one word per cycle while no skid word is held; the bit-per-stage root and divider chain sets the depth
// reset: rst_n synchronous, clears all valid bits and loads the radius register with 100
`default_nettype none
`include "hsv_color_wheel_pixel_assert.svh"
module hsv_color_wheel_pixel (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [hcw_pkg::RAD_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hcw_pkg::hcw_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hcw_pkg::hcw_out_t           out_data
);
  import hcw_pkg::*;

  localparam logic [RAD_W-1:0] RAD_RESET = 10'd100;
  localparam int HP_W = FRAC_BITS + 3;

  // hue sectors
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;

  function automatic logic [BYTE_W-1:0] to_byte(input logic [FRAC_BITS:0] lvl);
    logic [FRAC_BITS+8:0] scaled;
    scaled = {lvl, 8'h00} - (FRAC_BITS+9)'(lvl);
    if (scaled[FRAC_BITS+8]) return 8'hFF;
    return scaled[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // radius register
  logic [RAD_W-1:0] rad_cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_cfg_r <= RAD_RESET;
    end else if (cfg_wr_en) begin
      rad_cfg_r <= cfg_wr_data;
    end
  end

  logic en;
  logic skid_valid_r, out_valid_r;
  hcw_out_t skid_r, out_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  // stage 0: offsets from the center and image bounds
  logic signed [DELTA_W-1:0] dx_nxt, dy_nxt, dx_s0_r, dy_s0_r;
  logic inb_nxt, inb_s0_r, v_s0_r;
  logic [RAD_W-1:0] rad_s0_r;
  assign dx_nxt  = $signed({1'b0, in_data.pixel_x}) - $signed({2'b00, rad_cfg_r});
  assign dy_nxt  = $signed({1'b0, in_data.pixel_y}) - $signed({2'b00, rad_cfg_r});
  assign inb_nxt = (in_data.pixel_x < {rad_cfg_r, 1'b0}) && (in_data.pixel_y < {rad_cfg_r, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s0_r <= 1'b0;
    end else if (en) begin
      v_s0_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx_s0_r  <= dx_nxt;
      dy_s0_r  <= dy_nxt;
      inb_s0_r <= inb_nxt;
      rad_s0_r <= rad_cfg_r;
    end
  end

  // stage 1: squares
  logic signed [2*DELTA_W-1:0] dxx, dyy;
  logic [D2_W-1:0] sqx_s1_r, sqy_s1_r;
  logic [SQ_W-1:0] rsq_s1_r;
  logic signed [DELTA_W-1:0] dx_s1_r, dy_s1_r;
  logic inb_s1_r, v_s1_r;
  logic [RAD_W-1:0] rad_s1_r;
  assign dxx = dx_s0_r * dx_s0_r;
  assign dyy = dy_s0_r * dy_s0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
    end else if (en) begin
      v_s1_r <= v_s0_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_s1_r <= dxx[D2_W-1:0];
      sqy_s1_r <= dyy[D2_W-1:0];
      rsq_s1_r <= rad_s0_r * rad_s0_r;
      dx_s1_r  <= dx_s0_r;
      dy_s1_r  <= dy_s0_r;
      inb_s1_r <= inb_s0_r;
      rad_s1_r <= rad_s0_r;
    end
  end

  // stage 2: circle test
  logic [D2_W:0] d2sum;
  logic [SQ_W-1:0] d2_s2_r;
  logic signed [DELTA_W-1:0] dx_s2_r, dy_s2_r, nvx, nvy;
  logic in_s2_r, v_s2_r;
  logic [RAD_W-1:0] rad_s2_r;
  assign d2sum = {1'b0, sqx_s1_r} + {1'b0, sqy_s1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s2_r <= 1'b0;
    end else if (en) begin
      v_s2_r <= v_s1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d2_s2_r  <= d2sum[SQ_W-1:0];
      in_s2_r  <= inb_s1_r && (d2sum <= (D2_W+1)'(rsq_s1_r));
      dx_s2_r  <= dx_s1_r;
      dy_s2_r  <= dy_s1_r;
      rad_s2_r <= rad_s1_r;
    end
  end

  // hue angle and saturation units run side by side
  logic [ANG_W-1:0] angle;
  logic [DIV_BITS-1:0] sat;
  assign nvx = -dx_s2_r;
  assign nvy = -dy_s2_r;

  hcw_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .vec_x (nvx),
    .vec_y (nvy),
    .angle (angle)
  );

  hcw_satdiv u_satdiv (
    .clk (clk),
    .en  (en),
    .d2  (d2_s2_r),
    .rad (rad_s2_r),
    .sat (sat)
  );

  // hue rounding and alignment with the saturation result
  logic [ANG_W:0] hue_sum;
  logic [FRAC_BITS-1:0] hue_d_r [HUE_DLY];
  assign hue_sum = {1'b0, angle} + HUE_RND;

  always_ff @(posedge clk) begin
    if (en) begin
      hue_d_r[0] <= hue_sum[ANG_W-1 -: FRAC_BITS];
      for (int k = 1; k < HUE_DLY; k++) begin
        hue_d_r[k] <= hue_d_r[k-1];
      end
    end
  end

  // valid and inside flags alongside the units
  logic [LAT_SAT-1:0] pv_r, pin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[LAT_SAT-2:0], v_s2_r};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pin_r <= {pin_r[LAT_SAT-2:0], in_s2_r};
    end
  end

  // color stage 0: sector and fraction
  logic [DIV_BITS-1:0] satc;
  logic [HP_W-1:0] hp;
  logic [FRAC_BITS:0] fpart, fsel;
  logic [2:0] sec_c0_r;
  logic [FRAC_BITS:0] fsel_c0_r, sat_c0_r;
  logic v_c0_r, in_c0_r;
  assign satc  = (sat > ONE) ? ONE : sat;
  assign hp    = HP_W'(hue_d_r[HUE_DLY-1]) * HP_W'(6);
  assign fpart = {1'b0, hp[FRAC_BITS-1:0]};
  assign fsel  = hp[FRAC_BITS] ? (ONE - fpart) : fpart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c0_r <= 1'b0;
    end else if (en) begin
      v_c0_r <= pv_r[LAT_SAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      in_c0_r   <= pin_r[LAT_SAT-1];
      sec_c0_r  <= hp[HP_W-1:FRAC_BITS];
      fsel_c0_r <= fsel;
      sat_c0_r  <= satc;
    end
  end

  // color stage 1: second largest component
  logic [2*FRAC_BITS+1:0] prod;
  logic [FRAC_BITS:0] xv_c1_r, sat_c1_r;
  logic [2:0] sec_c1_r;
  logic v_c1_r, in_c1_r;
  assign prod = sat_c0_r * fsel_c0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c1_r <= 1'b0;
    end else if (en) begin
      v_c1_r <= v_c0_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      xv_c1_r  <= prod[2*FRAC_BITS:FRAC_BITS];
      sat_c1_r <= sat_c0_r;
      sec_c1_r <= sec_c0_r;
      in_c1_r  <= in_c0_r;
    end
  end

  // color stage 2: channel levels
  logic [FRAC_BITS:0] mlev, rsel, gsel, bsel;
  logic [FRAC_BITS:0] lr_c2_r, lg_c2_r, lb_c2_r;
  logic v_c2_r, in_c2_r;
  assign mlev = ONE - sat_c1_r;

  always_comb begin
    case (sec_c1_r)
      SEC_RED_YEL: begin rsel = sat_c1_r; gsel = xv_c1_r;  bsel = '0;       end
      SEC_YEL_GRN: begin rsel = xv_c1_r;  gsel = sat_c1_r; bsel = '0;       end
      SEC_GRN_CYN: begin rsel = '0;       gsel = sat_c1_r; bsel = xv_c1_r;  end
      SEC_CYN_BLU: begin rsel = '0;       gsel = xv_c1_r;  bsel = sat_c1_r; end
      SEC_BLU_MAG: begin rsel = xv_c1_r;  gsel = '0;       bsel = sat_c1_r; end
      default:     begin rsel = sat_c1_r; gsel = '0;       bsel = xv_c1_r;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c2_r <= 1'b0;
    end else if (en) begin
      v_c2_r <= v_c1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lr_c2_r <= rsel + mlev;
      lg_c2_r <= gsel + mlev;
      lb_c2_r <= bsel + mlev;
      in_c2_r <= in_c1_r;
    end
  end

  // color stage 3: bytes, outside pixels transparent black
  hcw_out_t res_nxt, res_c3_r;
  logic v_c3_r;
  always_comb begin
    res_nxt = '0;
    if (in_c2_r) begin
      res_nxt.inside_res = 1'b1;
      res_nxt.red        = to_byte(lr_c2_r);
      res_nxt.green      = to_byte(lg_c2_r);
      res_nxt.blue       = to_byte(lb_c2_r);
      res_nxt.alpha      = 8'hFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c3_r <= 1'b0;
    end else if (en) begin
      v_c3_r <= v_c2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res_c3_r <= res_nxt;
    end
  end

  // output word plus skid word
  logic push, pop;
  assign push = en && v_c3_r;
  assign pop  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r  <= skid_r;
        skid_r <= res_c3_r;
      end else begin
        out_r <= res_c3_r;
      end
    end else if (push) begin
      skid_r <= res_c3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `HCW_ASSERT(a_skid_behind_head, !skid_valid_r || out_valid_r, "skid word without head word")
  `HCW_ASSERT_NEXT(a_skid_hold, skid_valid_r && !out_ready, out_valid_r && skid_valid_r, "stalled word lost")
  `HCW_ASSERT(a_outside_black, !(out_valid_r && !out_r.inside_res) || (out_r.alpha == '0 && out_r.red == '0 && out_r.green == '0 && out_r.blue == '0), "outside pixel not black")
  `HCW_ASSERT(a_inside_opaque, !(out_valid_r && out_r.inside_res) || out_r.alpha == 8'hFF, "inside pixel not opaque")

endmodule
`default_nettype wire

// ===== tb/tb_hsv_color_wheel_pixel.sv =====
`default_nettype none
module tb_hsv_color_wheel_pixel;
  timeunit 1ns;
  timeprecision 1ps;
  import hcw_pkg::*;

  // sender / receiver idling styles
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // one directed row: radius to use, pixel, and a typed result where obvious
  typedef struct {
    int       rad;
    int       px;
    int       py;
    bit       known;
    hcw_out_t res;
  } pixel_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [RAD_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  hcw_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  hcw_out_t             out_data;

  hcw_out_t             expected_pixels[$];
  pixel_row_t           rows[$];
  int unsigned          mismatches;
  int unsigned          cur_radius;
  idle_mode_e           idle_mode;
  bit                   hold_request;

  hsv_color_wheel_pixel u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // floor shift for signed values
  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // integer square root, bit by bit
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // vectoring cordic, angle in binary turns
  function automatic logic [31:0] vector_turns(longint vx, longint vy);
    longint      x;
    longint      y;
    longint      nx;
    longint      ny;
    logic [31:0] z;
    x = vx * (64'sd1 << VEC_SHIFT);
    y = vy * (64'sd1 << VEC_SHIFT);
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < ANGLE_TABLE_LEN; i++) begin
      if (y > 0) begin
        nx = x + asr(y, i);
        ny = y - asr(x, i);
        z  = z + ATAN_TURNS[i];
      end else begin
        nx = x - asr(y, i);
        ny = y + asr(x, i);
        z  = z - ATAN_TURNS[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  // fraction level to 8-bit channel
  function automatic logic [7:0] level_to_byte(longint unsigned level);
    longint unsigned v;
    v = (level * 255) >> FRAC_BITS;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // color of one pixel of the wheel
  function automatic hcw_out_t wheel_color(int unsigned rad, int unsigned px, int unsigned py);
    longint          dx;
    longint          dy;
    longint unsigned d2;
    longint unsigned one;
    longint unsigned hue;
    longint unsigned sat;
    longint unsigned hp;
    longint unsigned frac;
    longint unsigned xv;
    longint unsigned m;
    longint unsigned r;
    longint unsigned g;
    longint unsigned b;
    int unsigned     sector;
    logic [31:0]     ang;
    hcw_out_t        res;
    one = 64'd1 << FRAC_BITS;
    dx  = longint'(px) - longint'(rad);
    dy  = longint'(py) - longint'(rad);
    d2  = dx * dx + dy * dy;
    res = '0;
    if (px >= 2 * rad || py >= 2 * rad || d2 > longint'(rad) * longint'(rad))
      return res;
    ang = vector_turns(-dx, -dy);
    hue = ((64'(ang) + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS)) & (one - 1);
    sat = (floor_sqrt(d2 << (2 * DIST_FRAC)) << FRAC_BITS) / (64'(rad) << DIST_FRAC);
    if (sat > one) sat = one;
    hp     = hue * 6;
    sector = int'(hp >> FRAC_BITS);
    frac   = hp & (one - 1);
    if (sector % 2 == 0) xv = (sat * frac) >> FRAC_BITS;
    else                 xv = (sat * (one - frac)) >> FRAC_BITS;
    m = one - sat;
    case (sector)
      0:       begin r = sat; g = xv;  b = 0;   end
      1:       begin r = xv;  g = sat; b = 0;   end
      2:       begin r = 0;   g = sat; b = xv;  end
      3:       begin r = 0;   g = xv;  b = sat; end
      4:       begin r = xv;  g = 0;   b = sat; end
      default: begin r = sat; g = 0;   b = xv;  end
    endcase
    res.inside_res = 1'b1;
    res.red        = level_to_byte(r + m);
    res.green      = level_to_byte(g + m);
    res.blue       = level_to_byte(b + m);
    res.alpha      = 8'd255;
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  // drive one pixel word, then hold it until accepted
  task automatic send_pixel(int unsigned px, int unsigned py, bit known, hcw_out_t res);
    @(negedge clk);
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < 65) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 15)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data.pixel_x <= px[COORD_W-1:0];
    in_data.pixel_y <= py[COORD_W-1:0];
    do @(posedge clk); while (!in_ready);
    if (known) expected_pixels.push_back(res);
    else       expected_pixels.push_back(wheel_color(cur_radius, px, py));
  endtask

  // wait for the pipe to empty, then load the radius
  task automatic set_radius(int unsigned rad);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rad[RAD_W-1:0];
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_radius   = rad;
  endtask

  // receiver back pressure
  always @(negedge clk) begin
    static int hold_left = 0;
    if (hold_request) begin
      hold_left    = 300;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_ready <= ($urandom_range(99) >= 65);
        IDLE_BOTH: out_ready <= ($urandom_range(99) >= 15);
        default:   out_ready <= 1'b1;
      endcase
    end
  end

  // compare each output word with the oldest expectation
  always @(posedge clk) begin
    hcw_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.inside_res != want.inside_res)
          report_mismatch("inside_res", out_data.inside_res, want.inside_res);
        if (out_data.red != want.red) report_mismatch("red", out_data.red, want.red);
        if (out_data.green != want.green)
          report_mismatch("green", out_data.green, want.green);
        if (out_data.blue != want.blue) report_mismatch("blue", out_data.blue, want.blue);
        if (out_data.alpha != want.alpha)
          report_mismatch("alpha", out_data.alpha, want.alpha);
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // main stimulus
  initial begin
    hcw_out_t    white;
    hcw_out_t    clear;
    int unsigned radii[8];
    int unsigned px;
    int unsigned py;
    int unsigned span;
    white        = '{1'b1, 8'd255, 8'd255, 8'd255, 8'd255};
    clear        = '0;
    radii        = '{100, 1023, 1, 0, 37, 1023, 512, 0};
    radii[7]     = $urandom_range(2, 1022);
    mismatches   = 0;
    cur_radius   = 100;
    idle_mode    = IDLE_NONE;
    hold_request = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed rows: reset radius, then extremes of the radius
    rows.push_back('{100, 100, 100, 1, white});
    rows.push_back('{100, 0, 0, 1, clear});
    rows.push_back('{100, 2047, 2047, 1, clear});
    rows.push_back('{100, 200, 100, 1, clear});
    rows.push_back('{100, 100, 200, 1, clear});
    rows.push_back('{100, 0, 100, 0, clear});
    rows.push_back('{100, 100, 0, 0, clear});
    rows.push_back('{100, 199, 100, 0, clear});
    rows.push_back('{100, 100, 199, 0, clear});
    rows.push_back('{100, 150, 150, 0, clear});
    rows.push_back('{100, 101, 100, 0, clear});
    rows.push_back('{100, 60, 130, 0, clear});
    rows.push_back('{1023, 1023, 1023, 1, white});
    rows.push_back('{1023, 0, 1023, 0, clear});
    rows.push_back('{1023, 2045, 1023, 0, clear});
    rows.push_back('{1023, 2046, 1023, 1, clear});
    rows.push_back('{1023, 0, 0, 1, clear});
    rows.push_back('{1023, 1500, 700, 0, clear});
    rows.push_back('{1, 1, 1, 1, white});
    rows.push_back('{1, 0, 1, 0, clear});
    rows.push_back('{1, 0, 0, 1, clear});
    rows.push_back('{1, 2, 1, 1, clear});
    rows.push_back('{0, 0, 0, 1, clear});
    rows.push_back('{0, 2047, 0, 1, clear});
    foreach (rows[i]) begin
      if (rows[i].rad != cur_radius) set_radius(rows[i].rad);
      send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].res);
    end

    // random phases over several radii and idling styles
    for (int ph = 0; ph < 8; ph++) begin
      set_radius(radii[ph]);
      idle_mode = idle_mode_e'(ph % 4);
      for (int n = 0; n < 116; n++) begin
        if (ph == 1 && n == 10) hold_request = 1'b1;
        span = 2 * cur_radius;
        if (span > 0 && $urandom_range(99) < 75) begin
          px = $urandom_range(span - 1);
          py = $urandom_range(span - 1);
        end else begin
          px = $urandom_range(2047);
          py = $urandom_range(2047);
        end
        send_pixel(px, py, 1'b0, clear);
      end
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    idle_mode = IDLE_NONE;
    wait (expected_pixels.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
